// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the envelope follower RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define AMEF_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Implication checked on every rising clock edge outside reset.
`define AMEF_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== rtl/amef_pkg.sv =====
package amef_pkg;

   localparam int PCM_W      = 16;
   localparam int LEN_W      = 7;
   localparam int GAIN_W     = 12;
   localparam int ALPHA_W    = 17;
   localparam int ENV_W      = 17;
   localparam int CNT_W      = 7;
   localparam int CSR_DATA_W = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   localparam int DEF_MAX_WINDOW = 64;

   // Q8 gain times sum over count, brought to Q16 of a 16-bit full scale
   localparam int GAIN_SHIFT = 7;

   localparam logic [ENV_W-1:0]   ONE_Q16         = 17'h10000;
   localparam logic [LEN_W-1:0]   RST_WINDOW_LEN  = 7'd64;
   localparam logic [GAIN_W-1:0]  RST_GAIN_Q8     = 12'd640;
   localparam logic [ALPHA_W-1:0] RST_ALPHA       = 17'd6554;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WINDOW_LEN   = 2'd0,
      REG_GAIN_Q8      = 2'd1,
      REG_SMOOTH_ALPHA = 2'd2,
      REG_SOURCE_READY = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_DSTART,
      S_DWAIT,
      S_ENV,
      S_UPD,
      S_EMIT
   } state_type;

endpackage

// ===== rtl/amef_div.sv =====
module amef_div #(
   parameter int DIV_W = 27,
   parameter int DEN_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DEN_W:0] rem_sh;
   logic [DEN_W:0] rem_nx;
   logic           fits;

   // Restoring division, one quotient bit a cycle; dividend shifts out as quotient shifts in
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DIV_W-1]};
      fits    = rem_sh >= {1'b0, den_ff};
      rem_nx  = fits ? (rem_sh - {1'b0, den_ff}) : rem_sh;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         step_in = STEP_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DIV_W-2:0], fits};
         rem_in  = rem_nx[DEN_W-1:0];
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/abs_mean_envelope_follower.sv =====
// Mean-absolute envelope follower. Each request word carries one signed 16-bit PCM sample
// (tuser marks it present, tlast ends the read). Magnitudes add up in a window that closes
// when its sample count reaches window_len (0 acts as 1, capped at MAX_WINDOW) or on tlast.
// An accumulating word leaves the block ready for the next; a closing word holds off new
// words until its result is issued. The serial divider yields one quotient bit a cycle; an
// empty window skips the divide. At close the mean, scaled by gain_q8 and clamped to 1.0 in
// Q16, feeds a one-pole smoother whose output goes out with the sample count; multiplies
// share one multiplier. With source_ready low, samples are dropped and a tlast word returns
// envelope 0, count 0. The user must write registers through csr_wen/csr_index/csr_wdata
// only while the block is idle; the block does not enforce this.
`include "assert_macros.svh"

module abs_mean_envelope_follower #(
   parameter int MAX_WINDOW = amef_pkg::DEF_MAX_WINDOW
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: tdata = pcm_sample[15:0]; tuser = has_sample; tlast = end_of_read
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [amef_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   // response: tdata = envelope[16:0], samples_used[23:17]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [amef_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_wen,
   input  logic [amef_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [amef_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import amef_pkg::*;

   localparam int SUM_W   = $clog2(MAX_WINDOW) + PCM_W;
   localparam int DIFF_W  = ENV_W + 1;
   localparam int MA_W    = (SUM_W + 1 > DIFF_W) ? SUM_W + 1 : DIFF_W;
   localparam int MP_W    = MA_W + DIFF_W;
   localparam int DIV_W   = SUM_W + GAIN_W - GAIN_SHIFT;
   localparam int CNT_MAX = (1 << CNT_W) - 1;
   localparam int CAP     = (MAX_WINDOW > CNT_MAX) ? CNT_MAX : MAX_WINDOW;
   localparam logic [CNT_W-1:0] CAP_V = CNT_W'(CAP);

   state_type state_ff, state_in;

   logic [LEN_W-1:0]   window_len_ff, window_len_in;
   logic [GAIN_W-1:0]  gain_ff, gain_in;
   logic [ALPHA_W-1:0] alpha_ff, alpha_in;
   logic               src_rdy_ff, src_rdy_in;

   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [ENV_W-1:0]   env_ff, env_in;
   logic [SUM_W-1:0]   op_sum_ff, op_sum_in;
   logic [CNT_W-1:0]   op_cnt_ff, op_cnt_in;
   logic [MP_W-1:0]    mprod_ff, mprod_in;
   logic [ENV_W-1:0]   norm_ff, norm_in;
   logic [ENV_W-1:0]   res_env_ff, res_env_in;
   logic [CNT_W-1:0]   res_cnt_ff, res_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ENV_W-1:0]   rsp_env_ff, rsp_env_in;
   logic [CNT_W-1:0]   rsp_cnt_ff, rsp_cnt_in;

   logic [PCM_W-1:0]         pcm;
   logic [PCM_W-1:0]         mag;
   logic [SUM_W-1:0]         sum_new;
   logic [CNT_W-1:0]         cnt_new;
   logic [CNT_W-1:0]         eff_len;
   logic                     close_win;
   logic                     accept;
   logic [ALPHA_W-1:0]       alpha_eff;
   logic signed [MA_W-1:0]   mult_a;
   logic signed [DIFF_W-1:0] mult_b;
   logic signed [MP_W-1:0]   mult_p;
   logic signed [DIFF_W-1:0] delta;
   logic signed [DIFF_W-1:0] env_sum;
   logic                     div_start;
   logic                     div_done;
   logic [DIV_W-1:0]         div_quo;

   amef_div #(
      .DIV_W(DIV_W),
      .DEN_W(CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mprod_ff[SUM_W+GAIN_W-1:GAIN_SHIFT]),
      .divisor  (op_cnt_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Datapath helpers
   always_comb begin
      pcm       = req_tdata[PCM_W-1:0];
      mag       = pcm[PCM_W-1] ? (~pcm + 1'b1) : pcm;
      sum_new   = sum_ff + (req_tuser ? SUM_W'(mag) : '0);
      cnt_new   = cnt_ff + CNT_W'(req_tuser);
      if (window_len_ff == '0) begin
         eff_len = CNT_W'(1);
      end else if (window_len_ff > CAP_V) begin
         eff_len = CAP_V;
      end else begin
         eff_len = window_len_ff;
      end
      close_win = req_tlast || (cnt_new >= eff_len);
      alpha_eff = (alpha_ff > ONE_Q16) ? ONE_Q16 : alpha_ff;
      // shared multiplier: sum * gain at close, then alpha * (norm - env)
      if (state_ff == S_MUL) begin
         mult_a = $signed({{(MA_W-SUM_W){1'b0}}, op_sum_ff});
         mult_b = $signed({{(DIFF_W-GAIN_W){1'b0}}, gain_ff});
      end else begin
         mult_a = $signed({{(MA_W-ALPHA_W){1'b0}}, alpha_eff});
         mult_b = $signed({1'b0, norm_ff}) - $signed({1'b0, env_ff});
      end
      mult_p  = mult_a * mult_b;
      // floor(alpha * diff / 2^16), two's complement
      delta   = $signed(mprod_ff[16+DIFF_W-1:16]);
      env_sum = $signed({1'b0, env_ff}) + delta;
   end

   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in      = state_ff;
      window_len_in = window_len_ff;
      gain_in       = gain_ff;
      alpha_in      = alpha_ff;
      src_rdy_in    = src_rdy_ff;
      sum_in        = sum_ff;
      cnt_in        = cnt_ff;
      env_in        = env_ff;
      op_sum_in     = op_sum_ff;
      op_cnt_in     = op_cnt_ff;
      mprod_in      = mprod_ff;
      norm_in       = norm_ff;
      res_env_in    = res_env_ff;
      res_cnt_in    = res_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_env_in    = rsp_env_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      div_start     = 1'b0;
      req_tready    = (state_ff == S_IDLE);

      if (csr_wen) begin
         case (reg_index_type'(csr_index))
            REG_WINDOW_LEN:   window_len_in = csr_wdata[LEN_W-1:0];
            REG_GAIN_Q8:      gain_in       = csr_wdata[GAIN_W-1:0];
            REG_SMOOTH_ALPHA: alpha_in      = csr_wdata[ALPHA_W-1:0];
            REG_SOURCE_READY: src_rdy_in    = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (!src_rdy_ff) begin
                  // silence: drop the sample, a tlast word returns zero
                  if (req_tlast) begin
                     sum_in     = '0;
                     cnt_in     = '0;
                     res_env_in = '0;
                     res_cnt_in = '0;
                     state_in   = S_EMIT;
                  end
               end else if (close_win) begin
                  op_sum_in = sum_new;
                  op_cnt_in = cnt_new;
                  sum_in    = '0;
                  cnt_in    = '0;
                  state_in  = S_MUL;
               end else begin
                  sum_in = sum_new;
                  cnt_in = cnt_new;
               end
            end
         end
         S_MUL: begin
            mprod_in = MP_W'(mult_p);
            if (op_cnt_ff == '0) begin
               norm_in  = '0;
               state_in = S_ENV;
            end else begin
               state_in = S_DSTART;
            end
         end
         S_DSTART: begin
            div_start = 1'b1;
            state_in  = S_DWAIT;
         end
         S_DWAIT: begin
            if (div_done) begin
               norm_in  = (div_quo > DIV_W'(ONE_Q16)) ? ONE_Q16 : div_quo[ENV_W-1:0];
               state_in = S_ENV;
            end
         end
         S_ENV: begin
            mprod_in = MP_W'(mult_p);
            state_in = S_UPD;
         end
         S_UPD: begin
            env_in     = env_sum[ENV_W-1:0];
            res_env_in = env_sum[ENV_W-1:0];
            res_cnt_in = op_cnt_ff;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_env_in   = res_env_ff;
               rsp_cnt_in   = res_cnt_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         window_len_ff <= RST_WINDOW_LEN;
         gain_ff       <= RST_GAIN_Q8;
         alpha_ff      <= RST_ALPHA;
         src_rdy_ff    <= 1'b0;
         sum_ff        <= '0;
         cnt_ff        <= '0;
         env_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         window_len_ff <= window_len_in;
         gain_ff       <= gain_in;
         alpha_ff      <= alpha_in;
         src_rdy_ff    <= src_rdy_in;
         sum_ff        <= sum_in;
         cnt_ff        <= cnt_in;
         env_ff        <= env_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_sum_ff  <= op_sum_in;
      op_cnt_ff  <= op_cnt_in;
      mprod_ff   <= mprod_in;
      norm_ff    <= norm_in;
      res_env_ff <= res_env_in;
      res_cnt_ff <= res_cnt_in;
      rsp_env_ff <= rsp_env_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_cnt_ff, rsp_env_ff};

   `AMEF_ASSERT(a_env_in_range, env_ff <= ONE_Q16, "envelope above 1.0")
   `AMEF_ASSERT_IMPL(a_div_done_wait, div_done, state_ff == S_DWAIT,
      "divider finished outside its wait state")
   `AMEF_ASSERT_IMPL(a_rsp_from_emit, $rose(rsp_valid_ff), $past(state_ff == S_EMIT),
      "response raised without a pending result")
   `AMEF_ASSERT_IMPL(a_silent_keeps_env, $past(accept && !src_rdy_ff), $stable(env_ff),
      "envelope changed while the source was down")

endmodule

// ===== dv/abs_mean_envelope_follower_tb.sv =====
`timescale 1ns / 100ps

module abs_mean_envelope_follower_tb;
   import amef_pkg::*;

   localparam int RANDOM_WORDS = 1150;
   localparam int DRAIN_CYCLES = 64;
   localparam int LIMIT_CYCLES = 500000;

   typedef struct {
      logic [ENV_W-1:0] env;
      logic [CNT_W-1:0] cnt;
   } envelope_word_type;

   typedef struct {
      bit                  is_cfg;
      logic [LEN_W-1:0]    len;
      logic [GAIN_W-1:0]   gain;
      logic [ALPHA_W-1:0]  alpha;
      logic                ready;
      logic [PCM_W-1:0]    sample;
      logic                has;
      logic                eor;
      bit                  typed;
      logic [ENV_W-1:0]    env;
      logic [CNT_W-1:0]    cnt;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = REG_WINDOW_LEN;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow registers and window state of the follower
   logic [LEN_W-1:0]   reg_len   = RST_WINDOW_LEN;
   logic [GAIN_W-1:0]  reg_gain  = RST_GAIN_Q8;
   logic [ALPHA_W-1:0] reg_alpha = RST_ALPHA;
   logic               reg_ready = 1'b0;
   logic [21:0]        abs_total = '0;
   logic [CNT_W-1:0]   open_count = '0;
   logic [ENV_W-1:0]   env_level = '0;

   envelope_word_type envelope_due[$];
   envelope_word_type due_word;
   plan_row_type      directed_plan[$];

   bit quiet = 1'b0;
   int fail_count = 0;
   int windows_seen = 0;
   int words_sent = 0;
   int settings_used = 0;
   int cycle_count = 0;

   abs_mean_envelope_follower uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Update the window with one word; returns 1 when the word closes a window.
   function automatic bit follow_word(input logic [PCM_W-1:0] s, input logic h,
                                      input logic e, output logic [ENV_W-1:0] env,
                                      output logic [CNT_W-1:0] cnt);
      logic [16:0]      mag;
      logic [LEN_W-1:0] eff;
      logic [33:0]      scaled;
      logic [16:0]      norm;
      logic [16:0]      a;
      logic [35:0]      mix;
      env = '0;
      cnt = '0;
      if (!reg_ready) begin
         if (e) begin
            abs_total = '0;
            open_count = '0;
            return 1'b1;
         end
         return 1'b0;
      end
      if (h) begin
         mag = s[PCM_W-1] ? (17'h10000 - 17'(s)) : 17'(s);
         abs_total = abs_total + mag;
         open_count = open_count + 1'b1;
      end
      if (reg_len == 0)
         eff = LEN_W'(1);
      else if (reg_len > DEF_MAX_WINDOW)
         eff = LEN_W'(DEF_MAX_WINDOW);
      else
         eff = reg_len;
      if (!(e || open_count >= eff))
         return 1'b0;
      norm = '0;
      if (open_count != 0) begin
         scaled = (abs_total * reg_gain) / (open_count * 128);
         norm = (scaled > ONE_Q16) ? ONE_Q16 : scaled[16:0];
      end
      a = (reg_alpha > ONE_Q16) ? ONE_Q16 : reg_alpha;
      mix = (36'(ONE_Q16) - a) * env_level + a * norm;
      env_level = mix[32:16];
      env = env_level;
      cnt = open_count;
      abs_total = '0;
      open_count = '0;
      return 1'b1;
   endfunction

   function automatic plan_row_type cfg_row(input logic [LEN_W-1:0] len,
                                            input logic [GAIN_W-1:0] gain,
                                            input logic [ALPHA_W-1:0] alpha,
                                            input logic ready);
      plan_row_type r;
      r = '{default: '0};
      r.is_cfg = 1'b1;
      r.len = len;
      r.gain = gain;
      r.alpha = alpha;
      r.ready = ready;
      return r;
   endfunction

   function automatic plan_row_type word_row(input logic [PCM_W-1:0] s, input logic h,
                                             input logic e, input bit typed,
                                             input logic [ENV_W-1:0] env,
                                             input logic [CNT_W-1:0] cnt);
      plan_row_type r;
      r = '{default: '0};
      r.sample = s;
      r.has = h;
      r.eor = e;
      r.typed = typed;
      r.env = env;
      r.cnt = cnt;
      return r;
   endfunction

   task automatic send_word(input logic [PCM_W-1:0] s, input logic h, input logic e,
                            input bit typed, input logic [ENV_W-1:0] env,
                            input logic [CNT_W-1:0] cnt);
      envelope_word_type w;
      while (!quiet && $urandom_range(0, 99) < 27) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= s;
      req_tuser <= h;
      req_tlast <= e;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      words_sent++;
      if (follow_word(s, h, e, w.env, w.cnt)) begin
         if (typed) begin
            w.env = env;
            w.cnt = cnt;
         end
         envelope_due.push_back(w);
      end
   endtask

   // Hold off until every window has come back and the block has gone quiet.
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (envelope_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [LEN_W-1:0] len, input logic [GAIN_W-1:0] gain,
                                input logic [ALPHA_W-1:0] alpha, input logic ready);
      drain_block();
      csr_wen <= 1'b1;
      csr_index <= REG_WINDOW_LEN;
      csr_wdata <= CSR_DATA_W'(len);
      @(posedge clock);
      reg_len = len;
      csr_index <= REG_GAIN_Q8;
      csr_wdata <= CSR_DATA_W'(gain);
      @(posedge clock);
      reg_gain = gain;
      csr_index <= REG_SMOOTH_ALPHA;
      csr_wdata <= CSR_DATA_W'(alpha);
      @(posedge clock);
      reg_alpha = alpha;
      csr_index <= REG_SOURCE_READY;
      csr_wdata <= CSR_DATA_W'(ready);
      @(posedge clock);
      reg_ready = ready;
      csr_wen <= 1'b0;
      settings_used++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (envelope_due.size() == 0) begin
            $error("unexpected response word: envelope %0d, samples_used %0d",
                   rsp_tdata[16:0], rsp_tdata[23:17]);
            fail_count++;
         end else begin
            due_word = envelope_due.pop_front();
            windows_seen++;
            if (rsp_tdata[16:0] !== due_word.env) begin
               $error("envelope mismatch: expected %0d, got %0d",
                      due_word.env, rsp_tdata[16:0]);
               fail_count++;
            end
            if (rsp_tdata[23:17] !== due_word.cnt) begin
               $error("samples_used mismatch: expected %0d, got %0d",
                      due_word.cnt, rsp_tdata[23:17]);
               fail_count++;
            end
         end
      end
      rsp_tready <= quiet || ($urandom_range(0, 99) >= 27);
   end

   initial begin
      int                 random_words;
      int                 n;
      int                 pick;
      plan_row_type       r;
      logic [LEN_W-1:0]   len_v;
      logic [GAIN_W-1:0]  gain_v;
      logic [ALPHA_W-1:0] alpha_v;
      logic [PCM_W-1:0]   s_v;
      logic               h_v;
      logic               e_v;
      logic               ready_v;

      // silent source straight after reset
      directed_plan.push_back(word_row(16'h0000, 1'b1, 1'b1, 1'b1, 17'd0, 7'd0));
      directed_plan.push_back(word_row(16'h1234, 1'b1, 1'b0, 1'b0, '0, '0));
      // full scale in both directions clamps to 1.0
      directed_plan.push_back(cfg_row(7'd1, 12'd4095, 17'd65536, 1'b1));
      directed_plan.push_back(word_row(16'h8000, 1'b1, 1'b0, 1'b1, 17'd65536, 7'd1));
      directed_plan.push_back(word_row(16'h7FFF, 1'b1, 1'b0, 1'b1, 17'd65536, 7'd1));
      directed_plan.push_back(word_row(16'h0000, 1'b1, 1'b0, 1'b1, 17'd0, 7'd1));
      // empty words: no close by length, close with no samples on tlast
      directed_plan.push_back(word_row(16'hFFFF, 1'b0, 1'b0, 1'b0, '0, '0));
      directed_plan.push_back(word_row(16'h5555, 1'b0, 1'b1, 1'b1, 17'd0, 7'd0));
      // zero length acts as one
      directed_plan.push_back(cfg_row(7'd0, 12'd0, 17'd0, 1'b1));
      directed_plan.push_back(word_row(16'd12345, 1'b1, 1'b0, 1'b1, 17'd0, 7'd1));
      // length past the cap, alpha past 1.0
      directed_plan.push_back(cfg_row(7'd127, 12'd256, 17'd131071, 1'b1));
      directed_plan.push_back(word_row(16'h4000, 1'b1, 1'b0, 1'b0, '0, '0));
      directed_plan.push_back(word_row(16'hC000, 1'b1, 1'b1, 1'b1, 17'd32768, 7'd2));
      // lower the length below the open count
      directed_plan.push_back(cfg_row(7'd64, 12'd640, 17'd6554, 1'b1));
      directed_plan.push_back(word_row(16'd1000, 1'b1, 1'b0, 1'b0, '0, '0));
      directed_plan.push_back(word_row(16'hF830, 1'b1, 1'b0, 1'b0, '0, '0));
      directed_plan.push_back(word_row(16'd3000, 1'b1, 1'b0, 1'b0, '0, '0));
      directed_plan.push_back(cfg_row(7'd2, 12'd640, 17'd6554, 1'b1));
      directed_plan.push_back(word_row(16'd500, 1'b1, 1'b0, 1'b0, '0, '0));
      // drop the source with a window open, then bring it back
      directed_plan.push_back(word_row(16'd7000, 1'b1, 1'b0, 1'b0, '0, '0));
      directed_plan.push_back(cfg_row(7'd2, 12'd640, 17'd6554, 1'b0));
      directed_plan.push_back(word_row(16'hFFFB, 1'b1, 1'b0, 1'b0, '0, '0));
      directed_plan.push_back(word_row(16'h0001, 1'b1, 1'b1, 1'b1, 17'd0, 7'd0));
      directed_plan.push_back(cfg_row(7'd3, 12'd640, 17'd6554, 1'b1));
      directed_plan.push_back(word_row(16'd100, 1'b1, 1'b1, 1'b0, '0, '0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[i]) begin
         r = directed_plan[i];
         if (r.is_cfg)
            apply_setting(r.len, r.gain, r.alpha, r.ready);
         else
            send_word(r.sample, r.has, r.eor, r.typed, r.env, r.cnt);
      end

      random_words = 0;
      while (random_words < RANDOM_WORDS) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0: len_v = 7'd0;
            1: len_v = 7'd64;
            2: len_v = LEN_W'($urandom_range(65, 127));
            3, 4: len_v = LEN_W'($urandom_range(1, 64));
            default: len_v = LEN_W'($urandom_range(1, 12));
         endcase
         pick = $urandom_range(0, 9);
         case (pick)
            0: gain_v = 12'd0;
            1: gain_v = 12'd4095;
            default: gain_v = GAIN_W'($urandom_range(0, 4095));
         endcase
         pick = $urandom_range(0, 9);
         case (pick)
            0: alpha_v = 17'd0;
            1: alpha_v = 17'd65536;
            2: alpha_v = ALPHA_W'($urandom_range(65537, 131071));
            3: alpha_v = 17'd131071;
            default: alpha_v = ALPHA_W'($urandom_range(0, 65536));
         endcase
         ready_v = ($urandom_range(0, 9) != 0);
         apply_setting(len_v, gain_v, alpha_v, ready_v);

         n = $urandom_range(20, 90);
         while (n > 0 && random_words < RANDOM_WORDS) begin
            n--;
            quiet = (random_words >= 300 && random_words < 550);
            pick = $urandom_range(0, 9);
            case (pick)
               0: s_v = 16'h8000;
               1: s_v = 16'h7FFF;
               2: s_v = 16'h0000;
               3: s_v = PCM_W'($urandom_range(0, 255)) - 16'd128;
               default: s_v = PCM_W'($urandom());
            endcase
            // mostly real samples, now and then an empty word or an early tlast
            h_v = ($urandom_range(0, 99) >= 12);
            e_v = ($urandom_range(0, 99) < 6);
            send_word(s_v, h_v, e_v, 1'b0, '0, '0);
            random_words++;
         end
      end

      quiet = 1'b0;
      drain_block();
      $display("%0d request words over %0d register settings, %0d windows checked",
               words_sent, settings_used, windows_seen);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/amef_pkg.sv
rtl/amef_div.sv
rtl/abs_mean_envelope_follower.sv
dv/abs_mean_envelope_follower_tb.sv
